// ===== design/srecord_s1_encoder_assert.svh =====
// Assertion macros shared by the S-record encoder RTL
`ifndef SRECORD_S1_ENCODER_ASSERT_SVH
`define SRECORD_S1_ENCODER_ASSERT_SVH

// check under reset disable
`define SREC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that also holds through reset
`define SREC_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/srec_pkg.sv =====
// Package: sizes, types, character codes and hex helper for the S1 record encoder
package srec_pkg;

  localparam int MAX_DATA_BYTES = 16;
  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
  localparam int CNT_W = $clog2(MAX_DATA_BYTES + 1);
  localparam int POS_W = $clog2(2 * MAX_DATA_BYTES + 11);
  localparam int ADDR_W = 16;

  localparam logic [6:0] CHAR_S = 7'h53;
  localparam logic [6:0] CHAR_ONE = 7'h31;
  localparam logic [6:0] CHAR_NL = 7'h0A;
  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_LETTER_BASE = 7'h37;
  localparam logic [7:0] COUNT_EXTRA = 8'd3;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [6:0] code;
    logic       eor;
  } char_beat_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    return (nib < 4'd10) ? 7'(ASCII_ZERO + wide) : 7'(ASCII_LETTER_BASE + wide);
  endfunction

endpackage

// ===== design/srec_out.sv =====
// Output register stage for record characters
module srec_out
  import srec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  char_beat_t beat,
  output logic       room,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [6:0] char_code,
  output logic       end_of_record
);

  assign room = !char_valid || !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (room) begin
      char_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (room && push) begin
      char_code     <= beat.code;
      end_of_record <= beat.eor;
    end
  end

endmodule

// ===== design/srecord_s1_encoder.sv =====
// Top level: Motorola S1 record encoder for a byte stream
//
// Input channel: data_byte with last_byte, handshake byte_valid / byte_stall.
// Output channel: one ASCII character per transaction on char_code, with
// end_of_record high on the closing newline; handshake char_valid / char_stall.
// Bytes are taken one per cycle into a 16-entry buffer memory. When the
// buffer fills or a byte carries last_byte, the block stalls its input and
// emits the record: "S1", count, address, data, checksum, newline, which is
// 11 + 2n characters for n data bytes, one per cycle while the receiver
// takes them. The first character passes the state register and then the
// output register after the transaction that closes the record. No new
// bytes are taken while a record is emitted; the single character output
// port sets the throughput. Data bytes are read back from the buffer memory
// through a read register ahead of their hex digits.
// Reset empties the buffer count, clears the address and checksum sum and
// leaves the output empty. A stall on the output holds the current character
// and freezes the record sequence until it is taken.
module srecord_s1_encoder
  import srec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [6:0] char_code,
  output logic       end_of_record
);

`include "srecord_s1_encoder_assert.svh"

  localparam logic [POS_W-1:0] POS_DATA = POS_W'(8);
  localparam logic [POS_W-1:0] POS_TAIL = POS_W'(10);

  state_t state, state_next;

  logic [7:0]        mem [MAX_DATA_BYTES];
  logic [7:0]        rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [3:0]        lo_nib;

  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W-1:0]  rec_len;
  logic              last_rec;
  logic [ADDR_W-1:0] record_address;
  logic [7:0]        running_sum;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  last_pos;
  logic [POS_W-1:0]  chk_pos;

  logic       byte_take;
  logic       push;
  logic       room;
  logic       emit_step;
  logic       rec_close;
  logic [7:0] count_byte;
  logic [7:0] chk_byte;
  logic [3:0] addr_nib;
  char_beat_t beat;

  assign byte_take = byte_valid && !byte_stall;
  assign emit_step = push && room;
  assign fill_inc  = CNT_W'(fill_count + CNT_W'(1));
  assign rec_close = byte_take && ((fill_inc >= CNT_W'(MAX_DATA_BYTES)) || last_byte);

  assign last_pos   = POS_W'(POS_W'({rec_len, 1'b0}) + POS_TAIL);
  assign chk_pos    = POS_W'(last_pos - POS_W'(2));
  assign count_byte = 8'(8'(rec_len) + COUNT_EXTRA);
  assign chk_byte   = ~8'(count_byte + record_address[15:8] + record_address[7:0] +
                          running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    byte_stall = 1'b1;
    push       = 1'b0;
    unique case (state)
      ST_FILL: begin
        byte_stall = 1'b0;
        if (rec_close) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        push = 1'b1;
        if (emit_step && (pos == last_pos)) begin
          state_next = ST_FILL;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      mem[fill_count[IDX_W-1:0]] <= data_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    unique case (pos[1:0])
      2'd0:    addr_nib = record_address[15:12];
      2'd1:    addr_nib = record_address[11:8];
      2'd2:    addr_nib = record_address[7:4];
      default: addr_nib = record_address[3:0];
    endcase
  end

  always_comb begin
    beat.eor = 1'b0;
    priority if (pos == POS_W'(0)) begin
      beat.code = CHAR_S;
    end else if (pos == POS_W'(1)) begin
      beat.code = CHAR_ONE;
    end else if (pos == POS_W'(2)) begin
      beat.code = hex_char(count_byte[7:4]);
    end else if (pos == POS_W'(3)) begin
      beat.code = hex_char(count_byte[3:0]);
    end else if (pos < POS_DATA) begin
      beat.code = hex_char(addr_nib);
    end else if (pos < chk_pos) begin
      beat.code = pos[0] ? hex_char(lo_nib) : hex_char(rd_data[7:4]);
    end else if (pos == chk_pos) begin
      beat.code = hex_char(chk_byte[7:4]);
    end else if (pos != last_pos) begin
      beat.code = hex_char(chk_byte[3:0]);
    end else begin
      beat.code = CHAR_NL;
      beat.eor  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      record_address <= '0;
      running_sum    <= '0;
      pos            <= '0;
    end else if (byte_take) begin
      running_sum <= 8'(running_sum + data_byte);
      pos         <= '0;
      if (!rec_close) begin
        fill_count <= fill_inc;
      end
    end else if (emit_step) begin
      if (pos == last_pos) begin
        fill_count     <= '0;
        running_sum    <= '0;
        record_address <= last_rec ? '0 : ADDR_W'(record_address + ADDR_W'(rec_len));
      end else begin
        pos <= POS_W'(pos + POS_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      rec_len  <= fill_inc;
      last_rec <= last_byte;
      rd_addr  <= '0;
    end else if (emit_step && (pos >= POS_DATA) && (pos < chk_pos) && !pos[0]) begin
      lo_nib  <= rd_data[3:0];
      rd_addr <= IDX_W'(rd_addr + IDX_W'(1));
    end
  end

  srec_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .beat          (beat),
    .room          (room),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .end_of_record (end_of_record)
  );

  `SREC_CHECK(a_fill_below_max, (state == ST_FILL) |-> (fill_count < CNT_W'(MAX_DATA_BYTES)), "buffer count reached the record size while filling")
  `SREC_CHECK(a_pos_in_record, (state == ST_EMIT) |-> (pos <= last_pos), "character position ran past the end of the record")
  `SREC_CHECK(a_eor_is_newline, (char_valid && end_of_record) |-> (char_code == CHAR_NL), "end of record flagged on a character that is not a newline")
  `SREC_CHECK(a_record_close, (emit_step && (pos == last_pos)) |=> ((state == ST_FILL) && (fill_count == '0) && (running_sum == '0)), "buffer not emptied after the closing newline")
  `SREC_CHECK_ALWAYS(a_reset_empty, rst |=> (!char_valid && (state == ST_FILL)), "output or sequencer not idle after reset")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the S1 record encoder: byte streams in, record characters checked
module testbench
  import srec_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 2_000_000;

  class s1_record_scoreboard;
    logic [7:0]  held_bytes[MAX_DATA_BYTES];
    int unsigned fill_level = 0;
    logic [15:0] next_address = 16'h0000;
    logic [7:0]  data_sum = 8'h00;
    char_beat_t  expected_chars[$];
    int unsigned mismatches = 0;
    int unsigned records_built = 0;
    int unsigned chars_checked = 0;

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function logic [6:0] hex_digit(logic [3:0] nib);
      return (nib < 4'd10) ? 7'(ASCII_ZERO + 7'(nib)) : 7'(ASCII_LETTER_BASE + 7'(nib));
    endfunction

    function void push_char(logic [6:0] code, logic eor);
      char_beat_t beat;
      beat.code = code;
      beat.eor = eor;
      expected_chars.push_back(beat);
    endfunction

    function void push_hex(logic [7:0] value);
      push_char(hex_digit(value[7:4]), 1'b0);
      push_char(hex_digit(value[3:0]), 1'b0);
    endfunction

    function void note_byte(logic [7:0] value, logic is_last);
      logic [7:0]  count_byte;
      logic [7:0]  check_sum;
      int unsigned n;
      held_bytes[fill_level] = value;
      n = fill_level + 1;
      data_sum = data_sum + value;
      if (n < MAX_DATA_BYTES && !is_last) begin
        fill_level = n;
        return;
      end
      count_byte = 8'(n) + COUNT_EXTRA;
      check_sum = count_byte + next_address[15:8] + next_address[7:0] + data_sum;
      push_char(CHAR_S, 1'b0);
      push_char(CHAR_ONE, 1'b0);
      push_hex(count_byte);
      push_hex(next_address[15:8]);
      push_hex(next_address[7:0]);
      for (int i = 0; i < n; i++)
        push_hex(held_bytes[i]);
      push_hex(~check_sum);
      push_char(CHAR_NL, 1'b1);
      fill_level = 0;
      data_sum = 8'h00;
      records_built++;
      next_address = is_last ? 16'h0000 : next_address + 16'(n);
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_char(logic [6:0] code, logic eor);
      char_beat_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("character %02h arrived with none expected", code));
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (code !== want.code)
        report($sformatf("char_code %02h, expected %02h", code, want.code));
      if (eor !== want.eor)
        report($sformatf("end_of_record %b, expected %b", eor, want.eor));
    endtask
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       char_valid;
  logic       char_stall = 1'b0;
  logic [6:0] char_code;
  logic       end_of_record;

  s1_record_scoreboard sb = new;

  int unsigned cycle_count = 0;
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run = 0;
  int unsigned bytes_sent = 0;

  srecord_s1_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .end_of_record(end_of_record)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // hold each stall level for a random run of cycles
  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      char_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      char_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_run <= $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall)
      sb.check_char(char_code, end_of_record);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 1;
    if (roll < 60) return $urandom_range(2, 15);
    if (roll < 70) return MAX_DATA_BYTES;
    if (roll < 78) return 2 * MAX_DATA_BYTES;
    return $urandom_range(MAX_DATA_BYTES + 1, 3 * MAX_DATA_BYTES);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    byte_valid <= 1'b1;
    data_byte <= value;
    last_byte <= is_last;
    do @(posedge clk); while (byte_stall);
    sb.note_byte(value, is_last);
    bytes_sent++;
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_image(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(pick_byte(), i == len - 1);
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] pattern[16];
    int unsigned target;
    pattern = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h01, 8'hFE,
                8'h55, 8'hAA, 8'h12, 8'h34, 8'h9C, 8'hDE, 8'h3B, 8'hC6};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 16; i++)
      send_byte(pattern[i], 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    target = bytes_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_max = 0;  stall_pct <= 0;  end
        1: begin gap_max = 6;  stall_pct <= 30; end
        2: begin gap_max = 2;  stall_pct <= 70; end
        default: begin gap_max = 12; stall_pct <= 10; end
      endcase
      target = target + 95;
      while (bytes_sent < target)
        send_image(pick_length());
      drain();
    end

    repeat (40) @(posedge clk);

    $display("Sent %0d bytes as %0d records; %0d characters checked.",
             bytes_sent, sb.records_built, sb.chars_checked);
    $display("Covered short and full records, last on a full buffer, idling and output stalls.");
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/srec_pkg.sv
design/srec_out.sv
design/srecord_s1_encoder.sv
tb/testbench.sv
